@@ sv/ghh_pkg.sv @@
// Shared types and codes for the gradient/hessian histogram core.
// Used by ghh_front, ghh_back and gradient_hessian_histogram_core.
`default_nettype none

package ghh_pkg;

    // Item kinds
    localparam logic KIND_ACC  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Widest cell index: 64 reachable features times 256 bins
    localparam int CELL_W = 14;

    localparam logic [47:0] GRAD_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] GRAD_MIN = 48'h8000_0000_0000;
    localparam logic [47:0] HESS_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic               kind;
        logic [5:0]         feature_index;
        logic [7:0]         bin_value;
        logic signed [23:0] gradient;
        logic [23:0]        hessian;
    } item_t;

    typedef struct packed {
        logic signed [47:0] grad_sum;
        logic [47:0]        hess_sum;
        logic               saturated;
    } result_t;

    // Classified command from front to back
    typedef struct packed {
        logic              is_read;
        logic              hit;
        logic [CELL_W-1:0] bin_addr;
        logic [23:0]       gradient;
        logic [23:0]       hessian;
    } cmd_t;

    // One histogram bin as stored
    typedef struct packed {
        logic [47:0] grad;
        logic [47:0] hess;
        logic        mark;
    } bin_t;

    typedef struct packed {
        logic clearing;
        logic exec;
    } back_stat_t;

endpackage

`default_nettype wire

@@ sv/gradient_hessian_histogram_core.sv @@
// Gradient/hessian histogram core for gradient-boosted tree training.
// Input queue side: push/full with item; result queue side: empty/pop with result.
// An accumulate transaction adds gradient and hessian into bin (feature_index,
// bin_value) with 48-bit saturation; a read transaction returns the bin's sums
// and saturation mark, then clears the bin. Out-of-range bins: accumulates are
// dropped, reads return all zero.
// After reset the bin memory is swept to zero, one bin per cycle, over all
// min(FEATURE_COUNT,64)*BIN_COUNT bins (16384 at defaults); full is high
// throughout.
// In the back end, IDLE pops each item and reads its bin through the
// registered memory read port; EXEC then computes and writes it back. A read
// waits in EXEC while the result queue is full. The next item is taken only
// after EXEC is left, which is also when a read's result enters the result queue.
// Items wait in a 4-entry command queue, results in a 2-entry result queue.
// When pop stays low and the result queue fills, the back end halts on the next
// read; the command queue then fills and full rises. Nothing is lost.
// Depends on ghh_pkg, ghh_front, ghh_fifo, ghh_back.
`default_nettype none

module gradient_hessian_histogram_core #(
    parameter int BIN_COUNT     = 256,
    parameter int FEATURE_COUNT = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  ghh_pkg::item_t    item,
    output logic              empty,
    input  wire logic         pop,
    output ghh_pkg::result_t  result
);

    logic                cmd_push;
    ghh_pkg::cmd_t       cmd_in;
    logic                cmd_full;
    ghh_pkg::cmd_t       cmd_out;
    logic                cmd_empty;
    logic                cmd_pop;
    logic                res_push;
    ghh_pkg::result_t    res_in;
    logic                res_full;
    ghh_pkg::back_stat_t back_stat;

    ghh_front #(
        .BIN_COUNT     (BIN_COUNT),
        .FEATURE_COUNT (FEATURE_COUNT)
    ) u_front (
        .push     (push),
        .item     (item),
        .full     (full),
        .q_full   (cmd_full),
        .clearing (back_stat.clearing),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    ghh_fifo #(
        .DEPTH (4),
        .T     (ghh_pkg::cmd_t)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cmd_push),
        .wdata (cmd_in),
        .full  (cmd_full),
        .rd    (cmd_pop),
        .rdata (cmd_out),
        .empty (cmd_empty)
    );

    ghh_back #(
        .BIN_COUNT     (BIN_COUNT),
        .FEATURE_COUNT (FEATURE_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_valid (!cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res       (res_in),
        .res_full  (res_full),
        .stat      (back_stat)
    );

    ghh_fifo #(
        .DEPTH (2),
        .T     (ghh_pkg::result_t)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_push),
        .wdata (res_in),
        .full  (res_full),
        .rd    (pop),
        .rdata (result),
        .empty (empty)
    );

    a_no_result_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        back_stat.clearing |-> (!res_push && !cmd_pop)
    ) else $error("back end active during clearing pass");

    a_drop_bad_accumulate: assert property (
        @(posedge clk) disable iff (!rst_n)
        (push && !full && !cmd_in.hit && !cmd_in.is_read) |-> !cmd_push
    ) else $error("out-of-range accumulate entered command queue");

    a_no_push_on_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full
    ) else $error("result pushed into a full result queue");

    a_pop_only_when_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (back_stat.exec && !back_stat.clearing)
    ) else $error("command popped without entering execute");

endmodule

`default_nettype wire

@@ sv/ghh_fifo.sv @@
// Small synchronous queue, power-of-two depth, first-word fall-through.
// Standalone; the entry type is a module parameter.
`default_nettype none

module ghh_fifo #(
    parameter int  DEPTH = 2,
    parameter type T     = logic
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr,
    input  T          wdata,
    output logic      full,
    input  wire logic rd,
    output T          rdata,
    output logic      empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    T             store [DEPTH];
    logic [PW:0]  wptr_reg, wptr_next;
    logic [PW:0]  rptr_reg, rptr_next;

    assign empty = (wptr_reg == rptr_reg);
    assign full  = (wptr_reg[PW] != rptr_reg[PW]) && (wptr_reg[PW-1:0] == rptr_reg[PW-1:0]);
    assign rdata = store[rptr_reg[PW-1:0]];

    assign wptr_next = (wr && !full)  ? wptr_reg + 1'b1 : wptr_reg;
    assign rptr_next = (rd && !empty) ? rptr_reg + 1'b1 : rptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr && !full)
        begin
            store[wptr_reg[PW-1:0]] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ sv/ghh_front.sv @@
// Front end: input handshake, address range check and cell index.
// Depends on ghh_pkg.
`default_nettype none

module ghh_front #(
    parameter int BIN_COUNT     = 256,
    parameter int FEATURE_COUNT = 64
) (
    input  wire logic     push,
    input  ghh_pkg::item_t item,
    output logic          full,
    input  wire logic     q_full,
    input  wire logic     clearing,
    output logic          cmd_push,
    output ghh_pkg::cmd_t cmd
);

    logic        accept;
    logic        hit;
    logic [31:0] cell_wide;

    assign full   = q_full || clearing;
    assign accept = push && !full;

    assign hit = (32'(item.feature_index) < 32'(FEATURE_COUNT))
              && (32'(item.bin_value) < 32'(BIN_COUNT));

    assign cell_wide = 32'(item.feature_index) * 32'(BIN_COUNT) + 32'(item.bin_value);

    always_comb
    begin
        cmd.is_read  = (item.kind == ghh_pkg::KIND_READ);
        cmd.hit      = hit;
        cmd.bin_addr = cell_wide[ghh_pkg::CELL_W-1:0];
        cmd.gradient = item.gradient;
        cmd.hessian  = item.hessian;
    end

    // accumulates to a nonexistent bin are dropped here
    assign cmd_push = accept && (hit || cmd.is_read);

endmodule

`default_nettype wire

@@ sv/ghh_back.sv @@
// Back end: bin memory, clearing pass, read-modify-write with saturation.
// Depends on ghh_pkg.
`default_nettype none

module ghh_back #(
    parameter int BIN_COUNT     = 256,
    parameter int FEATURE_COUNT = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  ghh_pkg::cmd_t       cmd,
    input  wire logic           cmd_valid,
    output logic                cmd_pop,
    output logic                res_push,
    output ghh_pkg::result_t    res,
    input  wire logic           res_full,
    output ghh_pkg::back_stat_t stat
);

    localparam int FEAT_USED = (FEATURE_COUNT < 64) ? FEATURE_COUNT : 64;
    localparam int DEPTH     = FEAT_USED * BIN_COUNT;
    localparam int AW        = $clog2(DEPTH);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    ghh_pkg::bin_t mem [DEPTH];

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    ghh_pkg::cmd_t cmd_reg;
    ghh_pkg::bin_t rd_data_reg;

    logic          exec_go;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    ghh_pkg::bin_t wr_data;
    ghh_pkg::bin_t upd;
    logic [48:0]   g_sum;
    logic [48:0]   h_sum;
    logic          g_ovf;

    assign cmd_pop = (state_reg == ST_IDLE) && cmd_valid;
    assign exec_go = (state_reg == ST_EXEC) && (!cmd_reg.is_read || !res_full);

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
    end

    // Saturating update of the bin just read
    always_comb
    begin
        g_sum = {rd_data_reg.grad[47], rd_data_reg.grad}
              + {{25{cmd_reg.gradient[23]}}, cmd_reg.gradient};
        h_sum = {1'b0, rd_data_reg.hess} + {25'd0, cmd_reg.hessian};
        g_ovf = g_sum[48] ^ g_sum[47];
        if (g_ovf)
        begin
            upd.grad = g_sum[48] ? ghh_pkg::GRAD_MIN : ghh_pkg::GRAD_MAX;
        end
        else
        begin
            upd.grad = g_sum[47:0];
        end
        upd.hess = h_sum[48] ? ghh_pkg::HESS_MAX : h_sum[47:0];
        upd.mark = rd_data_reg.mark || g_ovf || h_sum[48];
    end

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = exec_go && cmd_reg.hit;
            wr_addr = cmd_reg.bin_addr[AW-1:0];
            wr_data = cmd_reg.is_read ? '0 : upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd_pop)
        begin
            rd_data_reg <= mem[cmd.bin_addr[AW-1:0]];
        end
    end

    assign res_push = exec_go && cmd_reg.is_read;

    always_comb
    begin
        if (cmd_reg.hit)
        begin
            res.grad_sum  = rd_data_reg.grad;
            res.hess_sum  = rd_data_reg.hess;
            res.saturated = rd_data_reg.mark;
        end
        else
        begin
            res = '0;
        end
    end

    assign stat.clearing = (state_reg == ST_CLEAR);
    assign stat.exec     = (state_reg == ST_EXEC);

endmodule

`default_nettype wire

@@ tb/sv/gradient_hessian_histogram_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for gradient_hessian_histogram_core: a directed table, then random
// accumulate/read transactions, checked against the table's expected results or a local copy of the histogram bins.
// Depends on ghh_pkg and the core RTL.

module gradient_hessian_histogram_core_test;

    localparam int BINS        = 256;
    localparam int FEATURES    = 64;
    localparam int CELLS       = BINS * FEATURES;
    localparam int RANDOM_ROWS = 1350;

    localparam longint GRAD_HI = (longint'(1) <<< 47) - 1;
    localparam longint GRAD_LO = -(longint'(1) <<< 47);
    localparam longint unsigned HESS_HI = 64'hFFFF_FFFF_FFFF;

    localparam ghh_pkg::result_t CLEAR_BIN = '0;

    typedef struct {
        ghh_pkg::item_t   sample;
        bit               typed;
        ghh_pkg::result_t want;
    } vector_t;

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    logic             push  = 1'b0;
    logic             pop   = 1'b0;
    ghh_pkg::item_t   item  = '0;
    logic             full;
    logic             empty;
    ghh_pkg::result_t result;

    // Local copy of the bins
    logic signed [47:0] grad_bins [CELLS] = '{default: '0};
    logic [47:0]        hess_bins [CELLS] = '{default: '0};
    logic               sat_bins  [CELLS] = '{default: 1'b0};

    ghh_pkg::result_t pending_reads [$];
    logic [13:0]      hot_cells [4];
    int               mismatches = 0;

    // Saturating sums need about 2^24 accumulates per bin, far beyond this run;
    // the clamp logic below is kept for completeness.
    vector_t directed [17] = '{
        '{'{ghh_pkg::KIND_READ, 6'd0,  8'd0,   24'h00_0000, 24'h00_0000}, 1'b1, CLEAR_BIN},
        '{'{ghh_pkg::KIND_ACC,  6'd63, 8'd255, 24'h7F_FFFF, 24'hFF_FFFF}, 1'b0, CLEAR_BIN},
        '{'{ghh_pkg::KIND_READ, 6'd63, 8'd255, 24'h00_0000, 24'h00_0000}, 1'b1,
          '{48'sh00_0000_7F_FFFF, 48'h00_0000_FF_FFFF, 1'b0}},
        '{'{ghh_pkg::KIND_READ, 6'd63, 8'd255, 24'h00_0000, 24'h00_0000}, 1'b1, CLEAR_BIN},
        '{'{ghh_pkg::KIND_ACC,  6'd0,  8'd0,   24'h80_0000, 24'h00_0000}, 1'b0, CLEAR_BIN},
        '{'{ghh_pkg::KIND_READ, 6'd0,  8'd0,   24'h00_0000, 24'h00_0000}, 1'b1,
          '{48'shFFFF_FF80_0000, 48'h0, 1'b0}},
        // back-to-back hits on one bin
        '{'{ghh_pkg::KIND_ACC,  6'd21, 8'd170, 24'h7F_FFFF, 24'hFF_FFFF}, 1'b0, CLEAR_BIN},
        '{'{ghh_pkg::KIND_ACC,  6'd21, 8'd170, 24'h7F_FFFF, 24'hFF_FFFF}, 1'b0, CLEAR_BIN},
        '{'{ghh_pkg::KIND_ACC,  6'd21, 8'd170, 24'h80_0000, 24'h00_0001}, 1'b0, CLEAR_BIN},
        '{'{ghh_pkg::KIND_READ, 6'd21, 8'd170, 24'hFF_FFFF, 24'hFF_FFFF}, 1'b0, CLEAR_BIN},
        '{'{ghh_pkg::KIND_ACC,  6'd42, 8'd85,  24'h00_0001, 24'h12_3456}, 1'b0, CLEAR_BIN},
        '{'{ghh_pkg::KIND_READ, 6'd42, 8'd85,  24'h00_0000, 24'h00_0000}, 1'b0, CLEAR_BIN},
        // accumulate right behind the read-and-clear of the same bin
        '{'{ghh_pkg::KIND_ACC,  6'd42, 8'd85,  24'hFF_FFFF, 24'h00_0000}, 1'b0, CLEAR_BIN},
        '{'{ghh_pkg::KIND_ACC,  6'd42, 8'd86,  24'h00_0000, 24'hFF_FFFF}, 1'b0, CLEAR_BIN},
        '{'{ghh_pkg::KIND_READ, 6'd42, 8'd85,  24'h00_0000, 24'h00_0000}, 1'b0, CLEAR_BIN},
        '{'{ghh_pkg::KIND_READ, 6'd42, 8'd86,  24'h00_0000, 24'h00_0000}, 1'b0, CLEAR_BIN},
        '{'{ghh_pkg::KIND_READ, 6'd7,  8'd128, 24'h00_0000, 24'h00_0000}, 1'b1, CLEAR_BIN}
    };

    gradient_hessian_histogram_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #2 clk = ~clk;

    // Applies one transaction to the bin copy; returns 1 when it yields a result.
    function automatic bit bin_update(input ghh_pkg::item_t it, output ghh_pkg::result_t res);
        int              idx;
        longint          g;
        longint unsigned h;
        res = '0;
        if (int'(it.feature_index) >= FEATURES || int'(it.bin_value) >= BINS)
            return it.kind == ghh_pkg::KIND_READ;
        idx = int'(it.feature_index) * BINS + int'(it.bin_value);
        if (it.kind == ghh_pkg::KIND_READ)
        begin
            res.grad_sum   = grad_bins[idx];
            res.hess_sum   = hess_bins[idx];
            res.saturated  = sat_bins[idx];
            grad_bins[idx] = '0;
            hess_bins[idx] = '0;
            sat_bins[idx]  = 1'b0;
            return 1'b1;
        end
        g = longint'(grad_bins[idx]) + longint'($signed(it.gradient));
        if (g > GRAD_HI)
        begin
            g = GRAD_HI;
            sat_bins[idx] = 1'b1;
        end
        else if (g < GRAD_LO)
        begin
            g = GRAD_LO;
            sat_bins[idx] = 1'b1;
        end
        grad_bins[idx] = g[47:0];
        h = 64'(hess_bins[idx]) + 64'(it.hessian);
        if (h > HESS_HI)
        begin
            h = HESS_HI;
            sat_bins[idx] = 1'b1;
        end
        hess_bins[idx] = h[47:0];
        return 1'b0;
    endfunction

    // Mostly hits a few hot bins so sums build up between reads.
    function automatic ghh_pkg::item_t random_sample();
        ghh_pkg::item_t it;
        it.kind = ($urandom_range(0, 99) < 22) ? ghh_pkg::KIND_READ : ghh_pkg::KIND_ACC;
        if ($urandom_range(0, 3) != 0)
            {it.feature_index, it.bin_value} = hot_cells[$urandom_range(0, 3)];
        else
            {it.feature_index, it.bin_value} = 14'($urandom);
        case ($urandom_range(0, 7))
            0:       it.gradient = 24'h7F_FFFF;
            1:       it.gradient = 24'h80_0000;
            2:       it.gradient = 24'($urandom_range(0, 511)) - 24'd256;
            default: it.gradient = 24'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       it.hessian = 24'hFF_FFFF;
            1:       it.hessian = 24'h00_0000;
            2:       it.hessian = 24'($urandom_range(0, 255));
            default: it.hessian = 24'($urandom);
        endcase
        return it;
    endfunction

    task automatic send_sample(input ghh_pkg::item_t it, input int gap, input bit typed,
                               input ghh_pkg::result_t want);
        ghh_pkg::result_t predicted;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full) @(posedge clk);
        if (bin_update(it, predicted))
            pending_reads.push_back(typed ? want : predicted);
    endtask

    initial
    begin : stimulus
        ghh_pkg::item_t sample;
        bit             rush;
        rush = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // full stays high through the post-reset clearing sweep
        foreach (directed[i])
            send_sample(directed[i].sample, $urandom_range(0, 14), directed[i].typed,
                        directed[i].want);
        // hold off until every read so far has come back
        push <= 1'b0;
        do @(posedge clk); while (pending_reads.size() != 0);
        for (int n = 0; n < RANDOM_ROWS; n++)
        begin
            if (n % 128 == 0)
                foreach (hot_cells[k])
                    hot_cells[k] = 14'($urandom);
            if (n % 64 == 0)
                rush = ($urandom_range(0, 3) == 0);
            sample = random_sample();
            send_sample(sample, rush ? 0 : $urandom_range(0, 14), 1'b0, CLEAR_BIN);
        end
        push <= 1'b0;
        do @(posedge clk); while (pending_reads.size() != 0);
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : drain
        ghh_pkg::result_t want;
        int               stall;
        int               served;
        bit               rush;
        served = 0;
        rush   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (served % 32 == 0)
                rush = ($urandom_range(0, 3) == 0);
            stall = rush ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            served++;
            if (pending_reads.size() == 0)
            begin
                $error("result transaction with no read outstanding: grad_sum %0d hess_sum %0d",
                       result.grad_sum, result.hess_sum);
                mismatches++;
            end
            else
            begin
                want = pending_reads.pop_front();
                if (result.grad_sum !== want.grad_sum)
                begin
                    $error("grad_sum expected %0d got %0d", want.grad_sum, result.grad_sum);
                    mismatches++;
                end
                if (result.hess_sum !== want.hess_sum)
                begin
                    $error("hess_sum expected %0d got %0d", want.hess_sum, result.hess_sum);
                    mismatches++;
                end
                if (result.saturated !== want.saturated)
                begin
                    $error("saturated expected %0b got %0b", want.saturated, result.saturated);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #2ms;
        $error("timeout with %0d reads outstanding", pending_reads.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
